[src/mbv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mbv_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] REG_WHEEL_RADIUS = 3'd0;
  localparam logic [2:0] REG_HALF_AXIS_SUM = 3'd1;
  localparam logic [2:0] REG_COUNTS_PER_REV = 3'd2;
  localparam logic [2:0] REG_GEAR_RATIO = 3'd3;
  localparam logic [2:0] REG_USE_COUNTS = 3'd4;

  localparam logic [15:0] RST_WHEEL_RADIUS = 16'd5112;
  localparam logic [16:0] RST_HALF_AXIS_SUM = 17'd24085;
  localparam logic [15:0] RST_COUNTS_PER_REV = 16'd42;
  localparam logic [7:0] RST_GEAR_RATIO = 8'd5;
  localparam logic RST_USE_COUNTS = 1'b1;

  localparam logic [29:0] NS_PER_S = 30'd1000000000;
  localparam logic [13:0] SEC_PER_MIN = 14'd60;
  localparam logic [63:0] TWO_PI_Q32 = 64'd26986075409;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_SUM1,
    S_SUM2,
    S_SUM3,
    S_START,
    S_RUN,
    S_ERR
  } top_state_t;

  typedef enum logic [2:0] {
    P_IDLE,
    P_NUM1,
    P_NUM2,
    P_DEN,
    P_DIV1,
    P_RAD,
    P_DIV2,
    P_DONE
  } lane_phase_t;

  typedef struct packed {
    logic start;
    logic signed [63:0] sum;
    logic [63:0] dt;
    logic [23:0] nt;
    logic [7:0] gr;
    logic [15:0] radius;
    logic [16:0] hs;
    logic use_counts;
  } lane_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [31:0] value;
  } lane_res_t;

  function automatic logic signed [63:0] sadd64(logic signed [63:0] a, logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] ^ s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return signed'(s[63:0]);
  endfunction

  function automatic logic signed [63:0] ssub64(logic signed [63:0] a, logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] ^ s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return signed'(s[63:0]);
  endfunction

endpackage

`default_nettype wire

[src/mbv_chan_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface mbv_in_if;
  logic valid;
  logic ready;
  logic [31:0] stamp_sec;
  logic [29:0] stamp_nsec;
  logic signed [31:0] count_front_left;
  logic signed [31:0] count_front_right;
  logic signed [31:0] count_rear_left;
  logic signed [31:0] count_rear_right;
  logic signed [31:0] speed_front_left;
  logic signed [31:0] speed_front_right;
  logic signed [31:0] speed_rear_left;
  logic signed [31:0] speed_rear_right;

  modport source(output valid, stamp_sec, stamp_nsec, count_front_left, count_front_right,
                 count_rear_left, count_rear_right, speed_front_left, speed_front_right,
                 speed_rear_left, speed_rear_right, input ready);
  modport sink(input valid, stamp_sec, stamp_nsec, count_front_left, count_front_right,
               count_rear_left, count_rear_right, speed_front_left, speed_front_right,
               speed_rear_left, speed_rear_right, output ready);
endinterface

interface mbv_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] yaw_rate;
  logic status;

  modport source(output valid, vel_x, vel_y, yaw_rate, status, input ready);
  modport sink(input valid, vel_x, vel_y, yaw_rate, status, output ready);
endinterface

`default_nettype wire

[src/mecanum_body_velocity_from_encoders_core.sv]
// Mecanum body velocity from four wheel samples.
// The input channel takes one timestamped sample of the four wheels per transfer.
// The first sample after reset only primes the stored counts and time and yields
// no result; every later sample yields one result transfer on the output channel
// with vel_x, vel_y and yaw_rate in signed fixed point and a status bit that is set
// when the elapsed time is zero or negative (the velocities are then zero).
// Three lanes, one per body axis, work on the sample side by side, each with a
// 32x32 multiplier stepped over partial products and a one-bit-per-cycle 128-bit
// divider; a merging stage collects the three into the output register.
// The yaw lane takes longest, as it runs the 128-step divider twice. One sample
// is processed at a time. The input is ready only while no sample is in work;
// a finished result waits in the output register while the receiver stalls, and
// the next sample is taken meanwhile. Reset restores the register defaults and
// forgets the primed sample. Registers are to be written over the APB-style port
// only while no sample is in work; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module mecanum_body_velocity_from_encoders_core
  import mbv_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  mbv_in_if.sink                     in_if,
  mbv_out_if.source                  out_if,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic [15:0] radius_r;
  logic [16:0] hs_r;
  logic [15:0] cpr_r;
  logic [7:0] gr_r;
  logic use_counts_r;
  logic [2:0] reg_idx;
  logic cfg_wr;

  top_state_t state_r, state_nxt;
  logic primed_r;
  logic accept;
  logic lane_start, lane_ack, load, can_load;

  logic [31:0] sec_r, prev_sec_r;
  logic [29:0] nsec_r, prev_nsec_r;
  logic signed [COUNT_WIDTH-1:0] cur_r [4];
  logic signed [COUNT_WIDTH-1:0] prev_r [4];
  logic signed [COUNT_WIDTH-1:0] in_cnt [4];
  logic signed [31:0] spd_r [4];
  logic signed [63:0] v_r [4];
  logic signed [63:0] v_nxt [4];
  logic signed [COUNT_WIDTH-1:0] dcnt [4];
  logic signed [63:0] in_c64 [4];
  logic signed [32:0] sec_d;
  logic signed [30:0] ns_s;
  logic signed [63:0] secprod_r, secprod_nxt;
  logic signed [30:0] nsd_r;
  logic signed [63:0] dt_r;
  logic signed [63:0] a1_r, b1_r, x2_r, y2_r, w2_r, sx_r, sy_r, sw_r;
  logic dt_bad;
  logic [23:0] nt;

  lane_cmd_t cmd_x, cmd_y, cmd_w;
  lane_res_t res_x, res_y, res_w;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RST_WHEEL_RADIUS;
      hs_r <= RST_HALF_AXIS_SUM;
      cpr_r <= RST_COUNTS_PER_REV;
      gr_r <= RST_GEAR_RATIO;
      use_counts_r <= RST_USE_COUNTS;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WHEEL_RADIUS: radius_r <= pwdata[15:0];
        REG_HALF_AXIS_SUM: hs_r <= pwdata[16:0];
        REG_COUNTS_PER_REV: cpr_r <= pwdata[15:0];
        REG_GEAR_RATIO: gr_r <= pwdata[7:0];
        REG_USE_COUNTS: use_counts_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WHEEL_RADIUS: prdata = {16'd0, radius_r};
      REG_HALF_AXIS_SUM: prdata = {15'd0, hs_r};
      REG_COUNTS_PER_REV: prdata = {16'd0, cpr_r};
      REG_GEAR_RATIO: prdata = {24'd0, gr_r};
      REG_USE_COUNTS: prdata = {31'd0, use_counts_r};
      default: prdata = '0;
    endcase
  end

  assign nt = 24'(cpr_r) * 24'(gr_r);

  always_comb begin
    in_c64[0] = 64'(in_if.count_front_left);
    in_c64[1] = 64'(in_if.count_front_right);
    in_c64[2] = 64'(in_if.count_rear_left);
    in_c64[3] = 64'(in_if.count_rear_right);
    for (int i = 0; i < 4; i++) begin
      in_cnt[i] = in_c64[i][COUNT_WIDTH-1:0];
      dcnt[i] = cur_r[i] - prev_r[i];
      v_nxt[i] = use_counts_r ? 64'(dcnt[i]) : 64'(spd_r[i]);
    end
    sec_d = signed'({1'b0, sec_r}) - signed'({1'b0, prev_sec_r});
    ns_s = signed'({1'b0, NS_PER_S});
    secprod_nxt = 64'(sec_d) * 64'(ns_s);
    dt_bad = dt_r[63] || (dt_r == 64'sd0);
  end

  always_comb begin
    state_nxt = state_r;
    in_if.ready = 1'b0;
    accept = 1'b0;
    lane_start = 1'b0;
    lane_ack = 1'b0;
    load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_if.ready = 1'b1;
        accept = in_if.valid;
        if (in_if.valid && primed_r) begin
          state_nxt = S_DIFF;
        end
      end
      S_DIFF: state_nxt = S_SUM1;
      S_SUM1: state_nxt = S_SUM2;
      S_SUM2: state_nxt = S_SUM3;
      S_SUM3: state_nxt = dt_bad ? S_ERR : S_START;
      S_START: begin
        lane_start = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (res_x.done && res_y.done && res_w.done && can_load) begin
          load = 1'b1;
          lane_ack = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ERR: begin
        if (can_load) begin
          load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      primed_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        primed_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sec_r <= in_if.stamp_sec;
      nsec_r <= in_if.stamp_nsec;
      cur_r <= in_cnt;
      spd_r[0] <= in_if.speed_front_left;
      spd_r[1] <= in_if.speed_front_right;
      spd_r[2] <= in_if.speed_rear_left;
      spd_r[3] <= in_if.speed_rear_right;
      if (!primed_r) begin
        prev_sec_r <= in_if.stamp_sec;
        prev_nsec_r <= in_if.stamp_nsec;
        prev_r <= in_cnt;
      end
    end
    if (state_r == S_DIFF) begin
      v_r <= v_nxt;
      secprod_r <= secprod_nxt;
      nsd_r <= signed'({1'b0, nsec_r}) - signed'({1'b0, prev_nsec_r});
      prev_r <= cur_r;
      prev_sec_r <= sec_r;
      prev_nsec_r <= nsec_r;
    end
    if (state_r == S_SUM1) begin
      dt_r <= secprod_r + 64'(nsd_r);
      a1_r <= sadd64(v_r[0], v_r[1]);
      b1_r <= ssub64(v_r[1], v_r[0]);
    end
    if (state_r == S_SUM2) begin
      x2_r <= sadd64(a1_r, v_r[2]);
      y2_r <= sadd64(b1_r, v_r[2]);
      w2_r <= ssub64(b1_r, v_r[2]);
    end
    if (state_r == S_SUM3) begin
      sx_r <= sadd64(x2_r, v_r[3]);
      sy_r <= ssub64(y2_r, v_r[3]);
      sw_r <= sadd64(w2_r, v_r[3]);
    end
  end

  always_comb begin
    cmd_x.start = lane_start;
    cmd_x.sum = sx_r;
    cmd_x.dt = dt_r;
    cmd_x.nt = nt;
    cmd_x.gr = gr_r;
    cmd_x.radius = radius_r;
    cmd_x.hs = hs_r;
    cmd_x.use_counts = use_counts_r;
    cmd_y = cmd_x;
    cmd_y.sum = sy_r;
    cmd_w = cmd_x;
    cmd_w.sum = sw_r;
  end

  mbv_lane #(.FRAC_BITS(FRAC_BITS), .YAW(1'b0)) u_lane_x (
    .clk(clk), .rst_n(rst_n), .cmd(cmd_x), .ack(lane_ack), .res(res_x)
  );

  mbv_lane #(.FRAC_BITS(FRAC_BITS), .YAW(1'b0)) u_lane_y (
    .clk(clk), .rst_n(rst_n), .cmd(cmd_y), .ack(lane_ack), .res(res_y)
  );

  mbv_lane #(.FRAC_BITS(FRAC_BITS), .YAW(1'b1)) u_lane_w (
    .clk(clk), .rst_n(rst_n), .cmd(cmd_w), .ack(lane_ack), .res(res_w)
  );

  mbv_merge u_merge (
    .clk(clk),
    .rst_n(rst_n),
    .load(load),
    .err(state_r == S_ERR),
    .res_x(res_x),
    .res_y(res_y),
    .res_w(res_w),
    .can_load(can_load),
    .out_if(out_if)
  );

  ap_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    lane_start |-> !(res_x.busy || res_y.busy || res_w.busy))
    else $error("lanes started while still busy");

  ap_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> can_load)
    else $error("result loaded over a pending transfer");

  ap_err_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ERR && load) |=> (out_if.valid && out_if.status))
    else $error("time error did not produce a status result");

  ap_idle_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !(res_x.busy || res_y.busy || res_w.busy))
    else $error("lane left busy after result transfer");

endmodule

`default_nettype wire

[src/mbv_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module mbv_lane
  import mbv_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter bit YAW = 1'b0
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire lane_cmd_t cmd,
  input  wire logic      ack,
  output lane_res_t      res
);

  localparam int SPD_SHIFT = 32 - FRAC_BITS;
  localparam int XY_SHIFT = 50 - FRAC_BITS;
  localparam int YAW_SHIFT = 34 - FRAC_BITS;

  lane_phase_t phase_r, phase_nxt;
  logic neg_r, neg_nxt;
  logic [127:0] num_r, num_nxt;
  logic [127:0] den_r, den_nxt;
  logic [127:0] rem_r, rem_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [127:0] ma_r, ma_nxt;
  logic [63:0] mb_r, mb_nxt;
  logic [2:0] mi_r, mi_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic [31:0] val_r, val_nxt;

  logic [31:0] wa, wb;
  logic [63:0] prod;
  logic [2:0] wsh;
  logic [127:0] term, acc_sum;
  logic mul_last;
  logic div_take;
  logic [127:0] div_sh, rem_step, num_step;
  logic [63:0] mag;
  logic [13:0] spd_den;

  function automatic logic [31:0] fin(logic [127:0] q, logic neg);
    logic [31:0] limit;
    logic [31:0] m;
    limit = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    m = ((|q[127:32]) || (q[31:0] > limit)) ? limit : q[31:0];
    return neg ? (32'd0 - m) : m;
  endfunction

  always_comb begin
    wa = ma_r[{mi_r[2:1], 5'b0} +: 32];
    wb = mb_r[{mi_r[0], 5'b0} +: 32];
    prod = {32'd0, wa} * {32'd0, wb};
    wsh = {1'b0, mi_r[2:1]} + {2'b0, mi_r[0]};
    term = {64'd0, prod} << {wsh, 5'b0};
    acc_sum = acc_r + term;
    mul_last = (mi_r == 3'd7);
    div_sh = {rem_r[126:0], num_r[127]};
    div_take = rem_r[127] || (div_sh >= den_r);
    rem_step = div_take ? (div_sh - den_r) : div_sh;
    num_step = {num_r[126:0], div_take};
    mag = cmd.sum[63] ? 64'(-cmd.sum) : 64'(cmd.sum);
    spd_den = SEC_PER_MIN * {6'd0, cmd.gr};
  end

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt = neg_r;
    num_nxt = num_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    acc_nxt = acc_r;
    ma_nxt = ma_r;
    mb_nxt = mb_r;
    mi_nxt = mi_r;
    cnt_nxt = cnt_r;
    val_nxt = val_r;
    unique case (phase_r)
      P_IDLE: begin
        if (cmd.start) begin
          neg_nxt = cmd.sum[63];
          acc_nxt = '0;
          mi_nxt = '0;
          rem_nxt = '0;
          cnt_nxt = '0;
          if (mag == 64'd0 || cmd.radius == 16'd0) begin
            val_nxt = '0;
            phase_nxt = P_DONE;
          end else if (cmd.use_counts) begin
            if (cmd.nt == 24'd0) begin
              val_nxt = fin('1, cmd.sum[63]);
              phase_nxt = P_DONE;
            end else begin
              ma_nxt = {64'd0, mag};
              mb_nxt = {34'd0, NS_PER_S};
              phase_nxt = P_NUM1;
            end
          end else begin
            if (cmd.gr == 8'd0) begin
              val_nxt = fin('1, cmd.sum[63]);
              phase_nxt = P_DONE;
            end else begin
              num_nxt = {64'd0, mag} << SPD_SHIFT;
              den_nxt = {114'd0, spd_den};
              phase_nxt = P_DIV1;
            end
          end
        end
      end
      P_NUM1: begin
        acc_nxt = acc_sum;
        mi_nxt = mi_r + 3'd1;
        if (mul_last) begin
          ma_nxt = acc_sum;
          mb_nxt = TWO_PI_Q32;
          acc_nxt = '0;
          phase_nxt = P_NUM2;
        end
      end
      P_NUM2: begin
        acc_nxt = acc_sum;
        mi_nxt = mi_r + 3'd1;
        if (mul_last) begin
          num_nxt = acc_sum;
          ma_nxt = {64'd0, cmd.dt};
          mb_nxt = {40'd0, cmd.nt};
          acc_nxt = '0;
          phase_nxt = P_DEN;
        end
      end
      P_DEN: begin
        acc_nxt = acc_sum;
        mi_nxt = mi_r + 3'd1;
        if (mul_last) begin
          den_nxt = acc_sum;
          phase_nxt = P_DIV1;
        end
      end
      P_DIV1: begin
        rem_nxt = rem_step;
        num_nxt = num_step;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd127) begin
          if (|num_step[127:96]) begin
            val_nxt = fin('1, neg_r);
            phase_nxt = P_DONE;
          end else begin
            ma_nxt = num_step;
            mb_nxt = {48'd0, cmd.radius};
            acc_nxt = '0;
            phase_nxt = P_RAD;
          end
        end
      end
      P_RAD: begin
        acc_nxt = acc_sum;
        mi_nxt = mi_r + 3'd1;
        if (mul_last) begin
          if (!YAW) begin
            val_nxt = fin(acc_sum >> XY_SHIFT, neg_r);
            phase_nxt = P_DONE;
          end else if (cmd.hs == 17'd0) begin
            val_nxt = fin('1, neg_r);
            phase_nxt = P_DONE;
          end else begin
            num_nxt = acc_sum;
            den_nxt = {111'd0, cmd.hs} << YAW_SHIFT;
            rem_nxt = '0;
            cnt_nxt = '0;
            phase_nxt = P_DIV2;
          end
        end
      end
      P_DIV2: begin
        rem_nxt = rem_step;
        num_nxt = num_step;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd127) begin
          val_nxt = fin(num_step, neg_r);
          phase_nxt = P_DONE;
        end
      end
      P_DONE: begin
        if (ack) begin
          phase_nxt = P_IDLE;
        end
      end
      default: begin
        phase_nxt = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    ma_r <= ma_nxt;
    mb_r <= mb_nxt;
    mi_r <= mi_nxt;
    cnt_r <= cnt_nxt;
    val_r <= val_nxt;
  end

  always_comb begin
    res.busy = (phase_r != P_IDLE);
    res.done = (phase_r == P_DONE);
    res.value = val_r;
  end

endmodule

`default_nettype wire

[src/mbv_merge.sv]
`timescale 1ns / 1ps
`default_nettype none

module mbv_merge
  import mbv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire logic      err,
  input  wire lane_res_t res_x,
  input  wire lane_res_t res_y,
  input  wire lane_res_t res_w,
  output logic           can_load,
  mbv_out_if.source      out_if
);

  logic valid_r;
  logic signed [31:0] vx_r, vy_r, vw_r;
  logic status_r;

  assign can_load = !valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_if.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vx_r <= err ? 32'sd0 : signed'(res_x.value);
      vy_r <= err ? 32'sd0 : signed'(res_y.value);
      vw_r <= err ? 32'sd0 : signed'(res_w.value);
      status_r <= err;
    end
  end

  assign out_if.valid = valid_r;
  assign out_if.vel_x = vx_r;
  assign out_if.vel_y = vy_r;
  assign out_if.yaw_rate = vw_r;
  assign out_if.status = status_r;

endmodule

`default_nettype wire

[sim/mbv_body_vel_checker.sv]
`timescale 1ns / 1ps

module mbv_body_vel_checker
  import mbv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  mbv_in_if                     in_ch,
  mbv_out_if                    out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    fails,
  output int                    pending
);

  typedef struct {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] wz;
    logic               st;
  } body_vel_t;

  body_vel_t vel_q[$];

  logic [15:0] radius;
  logic [16:0] hsum;
  logic [15:0] cpr;
  logic [7:0]  gear;
  logic        by_counts;

  logic               have_prev;
  logic [31:0]        last_sec;
  logic [29:0]        last_nsec;
  logic signed [31:0] last_cnt[4];

  assign pending = vel_q.size();

  function automatic logic [31:0] clamp_out(logic [127:0] q, bit neg);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) begin
      q = lim;
    end
    return neg ? 32'(-q[31:0]) : q[31:0];
  endfunction

  function automatic logic [31:0] axis_val(longint s, bit yaw, logic [63:0] dt);
    logic [63:0]  mag;
    logic [127:0] w;
    logic [127:0] den;
    logic [23:0]  nt;
    bit           neg;
    neg = s < 0;
    mag = neg ? 64'(-s) : 64'(s);
    if (mag == 0 || radius == 0) begin
      return 32'd0;
    end
    if (by_counts) begin
      nt = 24'(cpr) * 24'(gear);
      if (nt == 0) begin
        return clamp_out(128'd1 << 64, neg);
      end
      w = 128'(mag) * 128'(NS_PER_S) * 128'(TWO_PI_Q32);
      den = 128'(nt) * 128'(dt);
      w = w / den;
    end else begin
      den = 128'(SEC_PER_MIN) * 128'(gear);
      if (den == 0) begin
        return clamp_out(128'd1 << 64, neg);
      end
      w = (128'(mag) << 16) / den;
    end
    if (w >= (128'd1 << 96)) begin
      return clamp_out(128'd1 << 64, neg);
    end
    w = w * 128'(radius);
    if (yaw) begin
      if (hsum == 0) begin
        return clamp_out(128'd1 << 64, neg);
      end
      den = 128'(hsum) << 18;
    end else begin
      den = 128'd1 << 34;
    end
    return clamp_out(w / den, neg);
  endfunction

  task automatic predict_sample();
    longint    dt;
    longint    d[4];
    logic signed [31:0] cur[4];
    logic signed [31:0] diff;
    body_vel_t e;
    cur[0] = in_ch.count_front_left;
    cur[1] = in_ch.count_front_right;
    cur[2] = in_ch.count_rear_left;
    cur[3] = in_ch.count_rear_right;
    if (have_prev) begin
      dt = (longint'(in_ch.stamp_sec) - longint'(last_sec)) * 64'sd1000000000
         + (longint'(in_ch.stamp_nsec) - longint'(last_nsec));
      if (by_counts) begin
        for (int i = 0; i < 4; i++) begin
          diff = cur[i] - last_cnt[i];
          d[i] = longint'(diff);
        end
      end else begin
        d[0] = longint'(in_ch.speed_front_left);
        d[1] = longint'(in_ch.speed_front_right);
        d[2] = longint'(in_ch.speed_rear_left);
        d[3] = longint'(in_ch.speed_rear_right);
      end
      if (dt <= 0) begin
        e = '{32'd0, 32'd0, 32'd0, 1'b1};
      end else begin
        e.vx = axis_val(d[0] + d[1] + d[2] + d[3], 1'b0, 64'(dt));
        e.vy = axis_val(-d[0] + d[1] + d[2] - d[3], 1'b0, 64'(dt));
        e.wz = axis_val(-d[0] + d[1] - d[2] + d[3], 1'b1, 64'(dt));
        e.st = 1'b0;
      end
      vel_q.push_back(e);
    end
    have_prev = 1'b1;
    last_sec = in_ch.stamp_sec;
    last_nsec = in_ch.stamp_nsec;
    for (int i = 0; i < 4; i++) begin
      last_cnt[i] = cur[i];
    end
  endtask

  task automatic compare_result();
    body_vel_t e;
    if (vel_q.size() == 0) begin
      $display("%0t unexpected result: vel_x %h vel_y %h yaw_rate %h status %b", $time,
               out_ch.vel_x, out_ch.vel_y, out_ch.yaw_rate, out_ch.status);
      fails++;
      return;
    end
    e = vel_q.pop_front();
    if (out_ch.vel_x !== e.vx) begin
      $display("%0t vel_x mismatch: expected %h actual %h", $time, e.vx, out_ch.vel_x);
      fails++;
    end
    if (out_ch.vel_y !== e.vy) begin
      $display("%0t vel_y mismatch: expected %h actual %h", $time, e.vy, out_ch.vel_y);
      fails++;
    end
    if (out_ch.yaw_rate !== e.wz) begin
      $display("%0t yaw_rate mismatch: expected %h actual %h", $time, e.wz, out_ch.yaw_rate);
      fails++;
    end
    if (out_ch.status !== e.st) begin
      $display("%0t status mismatch: expected %b actual %b", $time, e.st, out_ch.status);
      fails++;
    end
  endtask

  initial begin
    fails = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      radius <= RST_WHEEL_RADIUS;
      hsum <= RST_HALF_AXIS_SUM;
      cpr <= RST_COUNTS_PER_REV;
      gear <= RST_GEAR_RATIO;
      by_counts <= RST_USE_COUNTS;
      have_prev = 1'b0;
      vel_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_WHEEL_RADIUS: radius <= pwdata[15:0];
          REG_HALF_AXIS_SUM: hsum <= pwdata[16:0];
          REG_COUNTS_PER_REV: cpr <= pwdata[15:0];
          REG_GEAR_RATIO: gear <= pwdata[7:0];
          REG_USE_COUNTS: by_counts <= pwdata[0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_sample();
      end
      if (out_ch.valid && out_ch.ready) begin
        compare_result();
      end
    end
  end

endmodule

[sim/mecanum_body_velocity_from_encoders_core_tb.sv]
`timescale 1ns / 1ps

module mecanum_body_velocity_from_encoders_core_tb;
  import mbv_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE = 400;

  typedef struct {
    logic [31:0]        sec;
    logic [29:0]        nsec;
    logic signed [31:0] cnt[4];
    logic signed [31:0] spd[4];
  } wheel_sample_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;
  int fails;
  int pending;
  int cycles;
  int send_gap_pct;
  int recv_stall_pct;

  wheel_sample_t smp;

  mbv_in_if in_ch();
  mbv_out_if out_ch();

  mecanum_body_velocity_from_encoders_core dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  mbv_body_vel_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fails(fails), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready = $urandom_range(99) >= recv_stall_pct;
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_all(logic [31:0] r, logic [31:0] h, logic [31:0] c, logic [31:0] g,
                         logic [31:0] u);
    drain();
    reg_write(REG_WHEEL_RADIUS, r);
    reg_write(REG_HALF_AXIS_SUM, h);
    reg_write(REG_COUNTS_PER_REV, c);
    reg_write(REG_GEAR_RATIO, g);
    reg_write(REG_USE_COUNTS, u);
  endtask

  task automatic push_sample();
    if ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.stamp_sec = smp.sec;
    in_ch.stamp_nsec = smp.nsec;
    in_ch.count_front_left = smp.cnt[0];
    in_ch.count_front_right = smp.cnt[1];
    in_ch.count_rear_left = smp.cnt[2];
    in_ch.count_rear_right = smp.cnt[3];
    in_ch.speed_front_left = smp.spd[0];
    in_ch.speed_front_right = smp.spd[1];
    in_ch.speed_rear_left = smp.spd[2];
    in_ch.speed_rear_right = smp.spd[3];
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic step_time(int unsigned dn);
    longint ns;
    ns = longint'(smp.nsec) + dn;
    while (ns >= 1000000000) begin
      ns -= 1000000000;
      smp.sec++;
    end
    smp.nsec = 30'(ns);
  endtask

  task automatic random_sample();
    int kind;
    kind = $urandom_range(99);
    if (kind < 80) begin
      step_time($urandom_range(1, 60000000));
      for (int i = 0; i < 4; i++) begin
        smp.cnt[i] = smp.cnt[i] + $signed(32'($urandom_range(0, 8000)) - 32'd4000);
      end
    end else if (kind < 88) begin
      if ($urandom_range(1)) begin
        smp.nsec = smp.nsec - 30'($urandom_range(0, 5));
      end
      for (int i = 0; i < 4; i++) begin
        smp.cnt[i] = smp.cnt[i] + $signed(32'($urandom_range(0, 200)) - 32'd100);
      end
    end else if (kind < 95) begin
      smp.sec = $urandom;
      smp.nsec = 30'($urandom);
      for (int i = 0; i < 4; i++) begin
        smp.cnt[i] = $urandom;
      end
    end else begin
      step_time($urandom_range(1, 2000));
      for (int i = 0; i < 4; i++) begin
        smp.cnt[i] = smp.cnt[i] + $urandom;
      end
    end
    for (int i = 0; i < 4; i++) begin
      smp.spd[i] = $urandom_range(1) ? $urandom
                                     : $signed(32'($urandom_range(0, 2000000)) - 32'd1000000);
    end
    push_sample();
  endtask

  task automatic random_config();
    logic [31:0] r;
    logic [31:0] h;
    logic [31:0] c;
    logic [31:0] g;
    r = $urandom_range(3) == 0 ? ($urandom_range(1) ? 32'd65535 : 32'd1)
                               : $urandom_range(1000, 40000);
    h = $urandom_range(3) == 0 ? ($urandom_range(1) ? 32'd131071 : 32'd1)
                               : $urandom_range(5000, 60000);
    c = $urandom_range(3) == 0 ? ($urandom_range(1) ? 32'd65535 : 32'd1)
                               : $urandom_range(8, 4096);
    g = $urandom_range(3) == 0 ? ($urandom_range(1) ? 32'd255 : 32'd1)
                               : $urandom_range(1, 100);
    set_all(r, h, c, g, $urandom_range(1));
  endtask

  initial begin
    cycles = 0;
    send_gap_pct = 9;
    recv_stall_pct = 50;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.stamp_sec = '0;
    in_ch.stamp_nsec = '0;
    in_ch.count_front_left = '0;
    in_ch.count_front_right = '0;
    in_ch.count_rear_left = '0;
    in_ch.count_rear_right = '0;
    in_ch.speed_front_left = '0;
    in_ch.speed_front_right = '0;
    in_ch.speed_rear_left = '0;
    in_ch.speed_rear_right = '0;
    out_ch.ready = 1'b0;
    smp.sec = 32'd100;
    smp.nsec = 30'd0;
    for (int i = 0; i < 4; i++) begin
      smp.cnt[i] = 32'h7FFF_FFF0;
      smp.spd[i] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The first sample only primes; then a plain step, zero and negative
    // elapsed time, a counter wrap and a large time jump.
    push_sample();
    step_time(10000000);
    smp.cnt = '{32'sh7FFF_FFF5, 32'sh7FFF_FFFF, 32'sh7FFF_FFE0, 32'sh7FFF_FFF0};
    push_sample();
    push_sample();
    smp.nsec = smp.nsec - 30'd1;
    push_sample();
    step_time(1);
    smp.cnt = '{32'sh8000_0010, 32'sh8000_0000, 32'sh7FFF_0000, 32'sh0};
    push_sample();
    smp.sec = 32'hFFFF_FFFF;
    smp.nsec = 30'h3FFF_FFFF;
    smp.cnt = '{32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF};
    push_sample();
    smp.sec = 32'd0;
    push_sample();
    smp.nsec = 30'h3FFF_FFFF;
    smp.cnt = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000};
    push_sample();

    set_all(65535, 1, 1, 1, 0);
    step_time(1000);
    smp.spd = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    push_sample();
    smp.spd = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
    push_sample();
    smp.spd = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000};
    push_sample();
    smp.spd = '{32'sh0, 32'sh0, 32'sh0, 32'sh0};
    push_sample();

    set_all(65535, 131071, 65535, 255, 0);
    smp.spd = '{32'sh0001_0000, 32'shFFFF_0000, 32'sh0000_0001, 32'sh7FFF_FFFF};
    push_sample();
    set_all(1, 0, 0, 0, 1);
    step_time(1);
    smp.cnt[1] = smp.cnt[1] + 32'sd5;
    push_sample();
    step_time(500);
    smp.cnt[0] = smp.cnt[0] - 32'sd3;
    push_sample();
    set_all(0, 24085, 42, 5, 1);
    step_time(500);
    smp.cnt[2] = smp.cnt[2] + 32'sd77;
    push_sample();
    set_all(1, 1, 65535, 255, 1);
    step_time(1);
    smp.cnt[3] = smp.cnt[3] + 32'sh4000_0000;
    push_sample();

    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct = ph == 0 ? 9 : (ph == 1 ? 50 : 0);
      recv_stall_pct = ph == 0 ? 50 : (ph == 1 ? 9 : 0);
      for (int ch = 0; ch < 10; ch++) begin
        random_config();
        for (int k = 0; k < 41; k++) begin
          if (ph == 1 && ch == 4 && k == 20) begin
            while (pending != 0) @(posedge clk);
            @(negedge clk);
          end
          random_sample();
        end
      end
    end

    drain();
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
